// ===== rtl/core/ttps_pkg.sv =====
// shared types and constants of the trapezoid turn profile sampler
package ttps_pkg;

    localparam int TIME_FRAC_BITS = 16;
    localparam int CFG_W          = 32;
    localparam int CFG_IDX_W      = 2;
    localparam int BASE_W         = 57;
    localparam int UP_W           = BASE_W + 1;

    localparam logic [CFG_IDX_W-1:0] REG_TURN_ANGLE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_LIMIT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_LIMIT = 2'd2;

    typedef enum logic [1:0] {
        PH_RAMP  = 2'd0,
        PH_COAST = 2'd1,
        PH_DOWN  = 2'd2,
        PH_DONE  = 2'd3
    } phase_t;

    typedef struct packed {
        logic              err;
        logic              neg;
        logic [31:0]       mag;
        logic [30:0]       peak;
        logic [31:0]       ramp;
        logic [32:0]       rc;
        logic [33:0]       dur;
        logic [BASE_W-1:0] bu;
        logic [BASE_W-1:0] base2;
    } profile_t;

endpackage

// ===== rtl/core/ttps_planner.sv =====
// profile planner: peak rate, ramp and coast times from the turn registers
module ttps_planner #(
    parameter int TIME_FRAC_BITS = ttps_pkg::TIME_FRAC_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               go,
    input  logic signed [31:0] turn_angle,
    input  logic [30:0]        rate_limit,
    input  logic [30:0]        accel_limit,
    output logic               busy,
    output ttps_pkg::profile_t prof
);

    localparam int T     = TIME_FRAC_BITS;
    localparam int NUM_W = 62 + T;
    localparam int CNT_W = $clog2(NUM_W + 1);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_MUL  = 7'b0000010,
        ST_CMP  = 7'b0000100,
        ST_SQRT = 7'b0001000,
        ST_DIV  = 7'b0010000,
        ST_PROD = 7'b0100000,
        ST_FIN  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic err_reg, err_next;
    logic neg_reg, neg_next;
    logic [31:0] mag_reg, mag_next;
    logic [62:0] pma_reg, pma_next;
    logic [61:0] ll_reg, ll_next;
    logic [61:0] al_reg, al_next;
    logic [30:0] peak_reg, peak_next;
    logic [31:0] ramp_reg, ramp_next;
    logic [31:0] coast_reg, coast_next;
    logic div_coast_reg, div_coast_next;
    logic [NUM_W-1:0] num_reg, num_next;
    logic [61:0] den_reg, den_next;
    logic [61:0] rem_reg, rem_next;
    logic [31:0] q_reg, q_next;
    logic sat_reg, sat_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [62:0] sv_reg, sv_next;
    logic [62:0] sres_reg, sres_next;
    logic [62:0] sb_reg, sb_next;
    logic [62:0] p1_reg, p1_next;
    logic [62:0] p2_reg, p2_next;
    logic [32:0] rc_reg, rc_next;
    logic [33:0] dur_reg, dur_next;
    logic [ttps_pkg::BASE_W-1:0] bu_reg, bu_next;
    logic [ttps_pkg::BASE_W-1:0] base2_reg, base2_next;

    logic [62:0] trial;
    logic        qbit;
    logic [31:0] q_step;
    logic        sat_step;
    logic [31:0] q_final;
    logic [62:0] ssum;
    logic [62:0] sres_step;

    always_comb
    begin
        state_next     = state_reg;
        err_next       = err_reg;
        neg_next       = neg_reg;
        mag_next       = mag_reg;
        pma_next       = pma_reg;
        ll_next        = ll_reg;
        al_next        = al_reg;
        peak_next      = peak_reg;
        ramp_next      = ramp_reg;
        coast_next     = coast_reg;
        div_coast_next = div_coast_reg;
        num_next       = num_reg;
        den_next       = den_reg;
        rem_next       = rem_reg;
        q_next         = q_reg;
        sat_next       = sat_reg;
        cnt_next       = cnt_reg;
        sv_next        = sv_reg;
        sres_next      = sres_reg;
        sb_next        = sb_reg;
        p1_next        = p1_reg;
        p2_next        = p2_reg;
        rc_next        = rc_reg;
        dur_next       = dur_reg;
        bu_next        = bu_reg;
        base2_next     = base2_reg;

        // restoring divider step
        trial    = {rem_reg, num_reg[NUM_W-1]};
        qbit     = (trial >= {1'b0, den_reg});
        q_step   = {q_reg[30:0], qbit};
        sat_step = sat_reg | q_reg[31];
        q_final  = sat_step ? 32'hFFFF_FFFF : q_step;

        // square root step
        ssum      = sres_reg + sb_reg;
        sres_step = (sv_reg >= ssum) ? ((sres_reg >> 1) + sb_reg) : (sres_reg >> 1);

        if (go)
        begin
            neg_next = turn_angle[31];
            mag_next = turn_angle[31] ? (32'd0 - turn_angle) : turn_angle;
            err_next = (rate_limit == 31'd0) || (accel_limit == 31'd0);
            state_next = ((rate_limit == 31'd0) || (accel_limit == 31'd0)) ? ST_IDLE : ST_MUL;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    state_next = ST_IDLE;
                end
                ST_MUL:
                begin
                    pma_next   = 63'(mag_reg) * 63'(accel_limit);
                    ll_next    = 62'(rate_limit) * 62'(rate_limit);
                    al_next    = 62'(accel_limit) * 62'(rate_limit);
                    state_next = ST_CMP;
                end
                ST_CMP:
                begin
                    rem_next = '0;
                    q_next   = '0;
                    sat_next = 1'b0;
                    cnt_next = CNT_W'(NUM_W);
                    if (pma_reg >= {1'b0, ll_reg})
                    begin
                        peak_next      = rate_limit;
                        num_next       = NUM_W'(pma_reg - {1'b0, ll_reg}) << T;
                        den_next       = al_reg;
                        div_coast_next = 1'b1;
                        state_next     = ST_DIV;
                    end
                    else
                    begin
                        coast_next = '0;
                        sv_next    = pma_reg;
                        sres_next  = '0;
                        sb_next    = 63'(1) << 62;
                        state_next = ST_SQRT;
                    end
                end
                ST_SQRT:
                begin
                    if (sv_reg >= ssum)
                    begin
                        sv_next = sv_reg - ssum;
                    end
                    sres_next = sres_step;
                    sb_next   = sb_reg >> 2;
                    if (sb_reg == 63'd1)
                    begin
                        peak_next      = sres_step[30:0];
                        num_next       = NUM_W'(sres_step[30:0]) << T;
                        den_next       = 62'(accel_limit);
                        rem_next       = '0;
                        q_next         = '0;
                        sat_next       = 1'b0;
                        cnt_next       = CNT_W'(NUM_W);
                        div_coast_next = 1'b0;
                        state_next     = ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    num_next = num_reg << 1;
                    rem_next = qbit ? 62'(trial - {1'b0, den_reg}) : trial[61:0];
                    q_next   = q_step;
                    sat_next = sat_step;
                    cnt_next = cnt_reg - CNT_W'(1);
                    if (cnt_reg == CNT_W'(1))
                    begin
                        if (div_coast_reg)
                        begin
                            coast_next     = q_final;
                            num_next       = NUM_W'(peak_reg) << T;
                            den_next       = 62'(accel_limit);
                            rem_next       = '0;
                            q_next         = '0;
                            sat_next       = 1'b0;
                            cnt_next       = CNT_W'(NUM_W);
                            div_coast_next = 1'b0;
                        end
                        else
                        begin
                            ramp_next  = q_final;
                            state_next = ST_PROD;
                        end
                    end
                end
                ST_PROD:
                begin
                    p1_next    = 63'(peak_reg) * 63'(ramp_reg);
                    p2_next    = 63'(peak_reg) * 63'(coast_reg);
                    rc_next    = 33'(ramp_reg) + 33'(coast_reg);
                    dur_next   = (34'(ramp_reg) << 1) + 34'(coast_reg);
                    state_next = ST_FIN;
                end
                ST_FIN:
                begin
                    bu_next    = ttps_pkg::BASE_W'(p1_reg >> (T + 1));
                    base2_next = ttps_pkg::BASE_W'(p1_reg >> (T + 1))
                               + ttps_pkg::BASE_W'(p2_reg >> T);
                    state_next = ST_IDLE;
                end
                default:
                begin
                    state_next = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            err_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            err_reg   <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg       <= neg_next;
        mag_reg       <= mag_next;
        pma_reg       <= pma_next;
        ll_reg        <= ll_next;
        al_reg        <= al_next;
        peak_reg      <= peak_next;
        ramp_reg      <= ramp_next;
        coast_reg     <= coast_next;
        div_coast_reg <= div_coast_next;
        num_reg       <= num_next;
        den_reg       <= den_next;
        rem_reg       <= rem_next;
        q_reg         <= q_next;
        sat_reg       <= sat_next;
        cnt_reg       <= cnt_next;
        sv_reg        <= sv_next;
        sres_reg      <= sres_next;
        sb_reg        <= sb_next;
        p1_reg        <= p1_next;
        p2_reg        <= p2_next;
        rc_reg        <= rc_next;
        dur_reg       <= dur_next;
        bu_reg        <= bu_next;
        base2_reg     <= base2_next;
    end

    assign busy       = (state_reg != ST_IDLE);
    assign prof.err   = err_reg;
    assign prof.neg   = neg_reg;
    assign prof.mag   = mag_reg;
    assign prof.peak  = peak_reg;
    assign prof.ramp  = ramp_reg;
    assign prof.rc    = rc_reg;
    assign prof.dur   = dur_reg;
    assign prof.bu    = bu_reg;
    assign prof.base2 = base2_reg;

endmodule

// ===== rtl/core/trapezoid_turn_profile_sampler.sv =====
// top level: turn registers, profile planner and the sample pipeline
//
// usage: write turn_angle, rate_limit and accel_limit through cfg_write,
// cfg_index and cfg_data. after reset and after every register write the
// planner works out peak rate, ramp and coast times with one shared
// bit-serial divider and square root; busy stays high for that time,
// which is shorter for a triangular profile or a zero limit.
// a sample transfer happens at a clock edge with start high and busy low;
// elapsed_time is taken there. each sample runs through a seven-stage
// pipeline of multipliers, adds and compares, so done pulses for one
// cycle when the sample leaves the last stage, with angle_now, rate_now,
// total_duration and limit_error valid in that cycle.
// throughput is one sample per cycle while the registers are left alone.
// the receiver cannot stall: every result is shown exactly once.
// rst_n clears the pipeline and loads the register defaults.
module trapezoid_turn_profile_sampler #(
    parameter int TIME_FRAC_BITS = ttps_pkg::TIME_FRAC_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [31:0]                elapsed_time,
    output logic                              busy,
    output logic                              done,
    output logic signed [31:0]                angle_now,
    output logic signed [31:0]                rate_now,
    output logic [31:0]                       total_duration,
    output logic                              limit_error,
    input  logic                              cfg_write,
    input  logic [ttps_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ttps_pkg::CFG_W-1:0]        cfg_data
);

    localparam int T      = TIME_FRAC_BITS;
    localparam int PROD_W = 93;
    localparam int DN_W   = 92 - 2 * T;
    localparam int AX_W   = 62 - T;
    localparam int UP_W   = ttps_pkg::UP_W;
    localparam int M_W    = (DN_W > UP_W) ? DN_W : UP_W;

    logic signed [31:0] turn_angle_reg;
    logic [30:0]        rate_limit_reg;
    logic [30:0]        accel_limit_reg;
    logic               dirty_reg;
    logic               plan_busy;
    ttps_pkg::profile_t prof;
    logic               accept;

    ttps_planner #(
        .TIME_FRAC_BITS(TIME_FRAC_BITS)
    ) u_planner (
        .clk        (clk),
        .rst_n      (rst_n),
        .go         (dirty_reg),
        .turn_angle (turn_angle_reg),
        .rate_limit (rate_limit_reg),
        .accel_limit(accel_limit_reg),
        .busy       (plan_busy),
        .prof       (prof)
    );

    assign busy   = cfg_write | dirty_reg | plan_busy;
    assign accept = start & ~busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            turn_angle_reg  <= '0;
            rate_limit_reg  <= 31'd16777216;
            accel_limit_reg <= 31'd16777216;
            dirty_reg       <= 1'b1;
        end
        else
        begin
            dirty_reg <= cfg_write;
            if (cfg_write)
            begin
                case (cfg_index)
                    ttps_pkg::REG_TURN_ANGLE:  turn_angle_reg  <= cfg_data;
                    ttps_pkg::REG_RATE_LIMIT:  rate_limit_reg  <= cfg_data[30:0];
                    ttps_pkg::REG_ACCEL_LIMIT: accel_limit_reg <= cfg_data[30:0];
                    default:
                    begin
                        turn_angle_reg <= turn_angle_reg;
                    end
                endcase
            end
        end
    end

    // valid bits
    logic [5:0] v_reg, v_next;
    logic       done_reg;

    // stage payloads
    logic [30:0]            t1_reg;
    ttps_pkg::phase_t       ph2_reg, ph2_next;
    logic [30:0]            x2_reg, x2_next;
    ttps_pkg::phase_t       ph3_reg;
    logic [61:0]            sq3_reg, ax3_reg, px3_reg;
    ttps_pkg::phase_t       ph4_reg;
    logic [62:0]            pl4_reg;
    logic [60:0]            phi4_reg;
    logic [UP_W-1:0]        up4_reg, up4_next;
    logic [30:0]            r4_reg, r4_next;
    ttps_pkg::phase_t       ph5_reg;
    logic [DN_W-1:0]        dn5_reg;
    logic [UP_W-1:0]        up5_reg;
    logic [30:0]            r5_reg;
    logic [M_W-1:0]         m6_reg, m6_next;
    logic [30:0]            r6_reg;
    logic signed [31:0]     angle_reg, angle_next;
    logic signed [31:0]     rate_reg, rate_next;
    logic [31:0]            dur_reg, dur_next;
    logic                   err_reg;

    logic [AX_W-1:0]        ax_sh;
    logic [PROD_W-1:0]      full;
    logic [31:0]            m_c;

    assign v_next = {v_reg[4:0], accept};

    // phase select
    always_comb
    begin
        if (33'(t1_reg) < 33'(prof.ramp))
        begin
            ph2_next = ttps_pkg::PH_RAMP;
            x2_next  = t1_reg;
        end
        else if (33'(t1_reg) < prof.rc)
        begin
            ph2_next = ttps_pkg::PH_COAST;
            x2_next  = 31'(t1_reg - prof.ramp);
        end
        else if (34'(t1_reg) < prof.dur)
        begin
            ph2_next = ttps_pkg::PH_DOWN;
            x2_next  = 31'(33'(t1_reg) - prof.rc);
        end
        else
        begin
            ph2_next = ttps_pkg::PH_DONE;
            x2_next  = '0;
        end
    end

    // rate and linear angle part
    assign ax_sh = AX_W'(ax3_reg >> T);

    always_comb
    begin
        up4_next = ((ph3_reg == ttps_pkg::PH_DOWN) ? UP_W'(prof.base2) : UP_W'(prof.bu))
                 + UP_W'(px3_reg >> T);
        case (ph3_reg)
            ttps_pkg::PH_RAMP:
            begin
                r4_next = (ax_sh > AX_W'(prof.peak)) ? prof.peak : ax_sh[30:0];
            end
            ttps_pkg::PH_COAST:
            begin
                r4_next = prof.peak;
            end
            ttps_pkg::PH_DOWN:
            begin
                r4_next = (ax_sh < AX_W'(prof.peak)) ? (prof.peak - ax_sh[30:0]) : '0;
            end
            default:
            begin
                r4_next = '0;
            end
        endcase
    end

    assign full = (PROD_W'(phi4_reg) << 32) + PROD_W'(pl4_reg);

    // angle magnitude
    always_comb
    begin
        case (ph5_reg)
            ttps_pkg::PH_RAMP:
            begin
                m6_next = M_W'(dn5_reg);
            end
            ttps_pkg::PH_COAST:
            begin
                m6_next = M_W'(up5_reg);
            end
            ttps_pkg::PH_DOWN:
            begin
                m6_next = (M_W'(up5_reg) > M_W'(dn5_reg)) ? (M_W'(up5_reg) - M_W'(dn5_reg)) : '0;
            end
            default:
            begin
                m6_next = M_W'(prof.mag);
            end
        endcase
    end

    // clamp and sign
    always_comb
    begin
        m_c = (m6_reg > M_W'(prof.mag)) ? prof.mag : m6_reg[31:0];
        if (prof.err)
        begin
            angle_next = '0;
            rate_next  = '0;
            dur_next   = '0;
        end
        else
        begin
            angle_next = prof.neg ? (32'd0 - m_c) : m_c;
            rate_next  = prof.neg ? (32'd0 - 32'(r6_reg)) : 32'(r6_reg);
            dur_next   = (prof.dur[33:32] != 2'd0) ? 32'hFFFF_FFFF : prof.dur[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg    <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            v_reg    <= v_next;
            done_reg <= v_reg[5];
        end
    end

    always_ff @(posedge clk)
    begin
        t1_reg    <= elapsed_time[31] ? 31'd0 : elapsed_time[30:0];
        ph2_reg   <= ph2_next;
        x2_reg    <= x2_next;
        ph3_reg   <= ph2_reg;
        sq3_reg   <= 62'(x2_reg) * 62'(x2_reg);
        ax3_reg   <= 62'(accel_limit_reg) * 62'(x2_reg);
        px3_reg   <= 62'(prof.peak) * 62'(x2_reg);
        ph4_reg   <= ph3_reg;
        pl4_reg   <= 63'(sq3_reg[31:0]) * 63'(accel_limit_reg);
        phi4_reg  <= 61'(sq3_reg[61:32]) * 61'(accel_limit_reg);
        up4_reg   <= up4_next;
        r4_reg    <= r4_next;
        ph5_reg   <= ph4_reg;
        dn5_reg   <= full[PROD_W-1 -: DN_W];
        up5_reg   <= up4_reg;
        r5_reg    <= r4_reg;
        m6_reg    <= m6_next;
        r6_reg    <= r5_reg;
        angle_reg <= angle_next;
        rate_reg  <= rate_next;
        dur_reg   <= dur_next;
        err_reg   <= prof.err;
    end

    assign done           = done_reg;
    assign angle_now      = angle_reg;
    assign rate_now       = rate_reg;
    assign total_duration = dur_reg;
    assign limit_error    = err_reg;

endmodule
